// ===== hw/rtl/mtlr_pkg.sv =====
// mtlr_pkg: shared constants, types and word functions for the legacy-twist
// mersenne twister draw unit; used by mtlr_cell, mtlr_chain and the top level
// no dependencies
package mtlr_pkg;

	localparam int unsigned STATE_WORDS  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned RANGE_SHIFT  = 31;
	localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

	localparam logic [31:0] SEED_MULT    = 32'd1812433253;
	localparam logic [31:0] TWIST_MAT    = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc60000;
	localparam logic [31:0] UPPER_MASK   = 32'h80000000;
	localparam logic [31:0] LOWER_MASK   = 32'h7fffffff;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;

	localparam logic [1:0] FUNC_SEED  = 2'd0;
	localparam logic [1:0] FUNC_RAW   = 2'd1;
	localparam logic [1:0] FUNC_RANGE = 2'd2;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_GEN,
		ST_MUL,
		ST_SUM
	} state_t;

	// fixed taps of the word chain
	typedef struct packed {
		word_t w_first;
		word_t w_second;
		word_t w_far;
		word_t w_last;
	} taps_t;

	function automatic word_t twist_word(word_t far_word, word_t cur, word_t nxt);
		word_t mixed;
		word_t mat;
		mixed = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		// legacy rule: matrix keyed on the low bit of the current word
		mat   = cur[0] ? TWIST_MAT : 32'd0;
		return far_word ^ (mixed >> 1) ^ mat;
	endfunction

	function automatic word_t seed_step(word_t prev, logic [IDX_W-1:0] idx);
		word_t x;
		word_t m;
		x = prev ^ (prev >> 30);
		m = SEED_MULT * x;
		return m + {{(32-IDX_W){1'b0}}, idx};
	endfunction

	function automatic logic [30:0] temper31(word_t w);
		word_t s;
		s = w;
		s = s ^ (s >> 11);
		s = s ^ ((s << 7) & TEMPER_B);
		s = s ^ ((s << 15) & TEMPER_C);
		s = s ^ (s >> 18);
		return s[31:1];
	endfunction

endpackage

// ===== hw/rtl/mtlr_cell.sv =====
// mtlr_cell: one 32-bit word of the twister state chain
// depends on mtlr_pkg for the word type
module mtlr_cell (
	input  logic           clk,
	input  logic           shift,
	input  mtlr_pkg::word_t d,
	output mtlr_pkg::word_t q
);

	mtlr_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ===== hw/rtl/mtlr_chain.sv =====
// mtlr_chain: row of mtlr_cell words shifting toward cell 0 one word a cycle while shift is high
// depends on mtlr_pkg and mtlr_cell
module mtlr_chain (
	input  logic            clk,
	input  logic            shift,
	input  mtlr_pkg::word_t shift_in,
	output mtlr_pkg::taps_t taps
);

	mtlr_pkg::word_t words [mtlr_pkg::STATE_WORDS];

	for (genvar i = 0; i < mtlr_pkg::STATE_WORDS; i++) begin : g_cell
		if (i == mtlr_pkg::STATE_WORDS - 1) begin : g_tail
			mtlr_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (shift_in),
				.q     (words[i])
			);
		end else begin : g_body
			mtlr_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (words[i+1]),
				.q     (words[i])
			);
		end
	end

	assign taps.w_first  = words[0];
	assign taps.w_second = words[1];
	assign taps.w_far    = words[mtlr_pkg::TWIST_OFFSET];
	assign taps.w_last   = words[mtlr_pkg::STATE_WORDS-1];

endmodule

// ===== hw/rtl/mersenne_twister_legacy_range.sv =====
// mersenne_twister_legacy_range: top level, command sequencer and range scaling
// depends on mtlr_pkg and mtlr_chain
//
// 32-bit mersenne twister (legacy twist) with raw and ranged draws. The state is
// a chain of 624 word cells holding the last 624 words of the sequence; a draw
// twists one new word from cells 0, 1 and 397, shifts it in and tempers it, so
// the table is never twisted as a whole. For a seed command the seed
// recurrence shifts one word a cycle into the chain, then the block is free
// again. A draw goes from transfer to result through twist, temper and
// partial products, and sum into the output register, after a fill from
// default_seed when it arrives before any seed. An empty range answers
// without touching the state. One command is in work at a time; the next is
// taken while a result still waits in the output register. The state needs
// no clearing after reset: it is only read once a seed filled it.
module mersenne_twister_legacy_range (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               default_seed_we,
	input  logic [31:0]        default_seed_wdata,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         func,
	input  logic [31:0]        seed_value,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] value,
	output logic               range_error
);

	localparam int unsigned IW = mtlr_pkg::IDX_W;

	mtlr_pkg::state_t state_q, state_d;
	mtlr_pkg::taps_t  taps;
	mtlr_pkg::word_t  shift_in;
	logic             shift;

	logic [31:0]      default_seed_q;
	logic             seeded_q;
	logic [IW-1:0]    fill_cnt_q;
	logic             draw_pend_q;
	mtlr_pkg::word_t  seed_val_q;
	logic             is_range_q;
	logic             err_q;
	logic [31:0]      lo_q;
	logic [32:0]      span_q;

	mtlr_pkg::word_t  w_s1;
	logic [30:0]      n_s2;
	logic [47:0]      p_hi_s2;
	logic [46:0]      p_lo_s2;

	logic             res_valid_q;
	logic [31:0]      value_q;
	logic             range_error_q;

	logic             accept;
	logic             empty_range;
	logic             fill_last;
	logic             out_free;
	mtlr_pkg::word_t  twisted;
	logic [63:0]      prod;
	logic [32:0]      q_scaled;
	logic [31:0]      diff;

	assign accept      = cmd_valid && !cmd_stall;
	assign empty_range = range_high < range_low;
	assign fill_last   = fill_cnt_q == IW'(mtlr_pkg::STATE_WORDS - 1);
	assign out_free    = !res_valid_q || !res_stall;
	assign twisted     = mtlr_pkg::twist_word(taps.w_far, taps.w_first, taps.w_second);
	assign diff        = range_high - range_low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		shift     = 1'b0;
		shift_in  = twisted;
		case (state_q)
			mtlr_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					case (func)
						mtlr_pkg::FUNC_SEED: state_d = mtlr_pkg::ST_FILL;
						mtlr_pkg::FUNC_RAW: begin
							state_d = seeded_q ? mtlr_pkg::ST_GEN : mtlr_pkg::ST_FILL;
						end
						mtlr_pkg::FUNC_RANGE: begin
							if (empty_range) begin
								state_d = mtlr_pkg::ST_SUM;
							end else begin
								state_d = seeded_q ? mtlr_pkg::ST_GEN : mtlr_pkg::ST_FILL;
							end
						end
						default: state_d = mtlr_pkg::ST_IDLE;
					endcase
				end
			end
			mtlr_pkg::ST_FILL: begin
				shift    = 1'b1;
				shift_in = (fill_cnt_q == '0) ? seed_val_q
					: mtlr_pkg::seed_step(taps.w_last, fill_cnt_q);
				if (fill_last) begin
					state_d = draw_pend_q ? mtlr_pkg::ST_GEN : mtlr_pkg::ST_IDLE;
				end
			end
			mtlr_pkg::ST_GEN: begin
				shift   = 1'b1;
				state_d = mtlr_pkg::ST_MUL;
			end
			mtlr_pkg::ST_MUL: state_d = mtlr_pkg::ST_SUM;
			mtlr_pkg::ST_SUM: begin
				if (out_free) begin
					state_d = mtlr_pkg::ST_IDLE;
				end
			end
			default: state_d = mtlr_pkg::ST_IDLE;
		endcase
	end

	mtlr_chain u_chain (
		.clk      (clk),
		.shift    (shift),
		.shift_in (shift_in),
		.taps     (taps)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_seed_q <= mtlr_pkg::DEFAULT_SEED;
			seeded_q       <= 1'b0;
			fill_cnt_q     <= '0;
			draw_pend_q    <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (default_seed_we) begin
				default_seed_q <= default_seed_wdata;
			end
			if (accept) begin
				fill_cnt_q  <= '0;
				draw_pend_q <= func != mtlr_pkg::FUNC_SEED;
			end else if (state_q == mtlr_pkg::ST_FILL) begin
				fill_cnt_q <= fill_cnt_q + IW'(1);
				if (fill_last) begin
					seeded_q <= 1'b1;
				end
			end
			if (state_q == mtlr_pkg::ST_SUM && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// command payload and scaling pipeline
	assign prod     = {p_hi_s2, 16'd0} + {17'd0, p_lo_s2};
	assign q_scaled = 33'(prod >> mtlr_pkg::RANGE_SHIFT);

	always_ff @(posedge clk) begin
		if (accept) begin
			seed_val_q <= (func == mtlr_pkg::FUNC_SEED) ? seed_value : default_seed_q;
			is_range_q <= func == mtlr_pkg::FUNC_RANGE;
			err_q      <= (func == mtlr_pkg::FUNC_RANGE) && empty_range;
			lo_q       <= range_low;
			span_q     <= {1'b0, diff} + 33'd1;
		end
		if (state_q == mtlr_pkg::ST_GEN) begin
			w_s1 <= twisted;
		end
		if (state_q == mtlr_pkg::ST_MUL) begin
			n_s2    <= mtlr_pkg::temper31(w_s1);
			// span split into a 17-bit upper and a 16-bit lower part keeps each product within 48 bits
			p_hi_s2 <= span_q[32:16] * mtlr_pkg::temper31(w_s1);
			p_lo_s2 <= span_q[15:0] * mtlr_pkg::temper31(w_s1);
		end
		if (state_q == mtlr_pkg::ST_SUM && out_free) begin
			range_error_q <= err_q;
			if (err_q) begin
				value_q <= '0;
			end else if (is_range_q) begin
				value_q <= lo_q + q_scaled[31:0];
			end else begin
				value_q <= {1'b0, n_s2};
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign value       = value_q;
	assign range_error = range_error_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for mersenne_twister_legacy_range, with a scoreboard
// class that predicts raw and ranged draws; needs mtlr_pkg and the top-level rtl
module tb_top;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int TW_WORDS = 624;
	localparam int TW_FAR = 397;
	localparam logic [31:0] MT_MULT = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
	localparam logic [31:0] MT_TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] MT_TEMPER_C = 32'hefc60000;
	localparam logic [31:0] RESET_SEED = 32'd5489;
	localparam logic signed [31:0] INT_MIN = 32'h80000000;
	localparam logic signed [31:0] INT_MAX = 32'h7fffffff;
	localparam int SETTLE_CYCLES = 700;

	typedef struct {
		logic [1:0]         op;
		logic [31:0]        seed;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} cmd_t;

	typedef struct {
		logic signed [31:0] value;
		logic               range_error;
	} draw_result_t;

	class draw_scoreboard;
		logic [31:0] words [TW_WORDS];
		int unsigned read_pos;
		int unsigned words_left;
		bit seeded;
		logic [31:0] fallback_seed;
		draw_result_t pending_draws[$];
		int mismatches;

		function new();
			read_pos = 0;
			words_left = 0;
			seeded = 0;
			fallback_seed = RESET_SEED;
			mismatches = 0;
		endfunction

		function void twist_all();
			logic [31:0] cur, nxt, far, mixed;
			for (int i = 0; i < TW_WORDS; i++) begin
				cur = words[i];
				nxt = words[(i + 1) % TW_WORDS];
				far = words[(i + TW_FAR) % TW_WORDS];
				mixed = {cur[31], nxt[30:0]};
				// matrix keyed on the low bit of the current word, not the next one
				words[i] = far ^ (mixed >> 1) ^ (cur[0] ? MT_MATRIX : 32'd0);
			end
			words_left = TW_WORDS;
			read_pos = 0;
		endfunction

		function void fill(input logic [31:0] s);
			logic [31:0] p;
			words[0] = s;
			for (int i = 1; i < TW_WORDS; i++) begin
				p = words[i - 1];
				words[i] = MT_MULT * (p ^ (p >> 30)) + i;
			end
			twist_all();
			seeded = 1;
		endfunction

		function logic [30:0] draw31();
			logic [31:0] s;
			if (words_left == 0)
				twist_all();
			words_left--;
			if (read_pos >= TW_WORDS)
				read_pos = 0;
			s = words[read_pos];
			read_pos++;
			s = s ^ (s >> 11);
			s = s ^ ((s << 7) & MT_TEMPER_B);
			s = s ^ ((s << 15) & MT_TEMPER_C);
			s = s ^ (s >> 18);
			return s[31:1];
		endfunction

		function void note_cmd(input cmd_t c);
			draw_result_t r;
			logic signed [63:0] lo64, hi64;
			logic [63:0] span, prod;
			logic [30:0] n;
			lo64 = c.lo;
			hi64 = c.hi;
			case (c.op)
				mtlr_pkg::FUNC_SEED: fill(c.seed);
				mtlr_pkg::FUNC_RAW: begin
					if (!seeded)
						fill(fallback_seed);
					r.value = {1'b0, draw31()};
					r.range_error = 1'b0;
					pending_draws.push_back(r);
				end
				mtlr_pkg::FUNC_RANGE: begin
					if (hi64 < lo64) begin
						// empty range leaves the table alone, even before any seed
						r.value = 32'sd0;
						r.range_error = 1'b1;
					end else begin
						if (!seeded)
							fill(fallback_seed);
						n = draw31();
						span = hi64 - lo64 + 64'sd1;
						prod = span * {33'd0, n};
						r.value = c.lo + prod[62:31];
						r.range_error = 1'b0;
					end
					pending_draws.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task report(input string msg);
			mismatches++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(input logic signed [31:0] got_value, input logic got_err);
			draw_result_t want;
			if (pending_draws.size() == 0) begin
				report($sformatf("unexpected result value %0d error %b", got_value, got_err));
				return;
			end
			want = pending_draws.pop_front();
			if (got_value !== want.value)
				report($sformatf("value %0d, expected %0d", got_value, want.value));
			if (got_err !== want.range_error)
				report($sformatf("range_error %b, expected %b", got_err, want.range_error));
		endtask

		task check_drained();
			while (pending_draws.size() > 0) begin
				void'(pending_draws.pop_front());
				report("expected draw result never came");
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               default_seed_we = 1'b0;
	logic [31:0]        default_seed_wdata = '0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	logic [1:0]         func = FUNC_NONE;
	logic [31:0]        seed_value = '0;
	logic signed [31:0] range_low = '0;
	logic signed [31:0] range_high = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [31:0] value;
	logic               range_error;

	bit calm = 1'b0;
	int item_count = 0;
	draw_scoreboard sb = new();

	mersenne_twister_legacy_range u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.default_seed_we    (default_seed_we),
		.default_seed_wdata (default_seed_wdata),
		.cmd_valid          (cmd_valid),
		.cmd_stall          (cmd_stall),
		.func               (func),
		.seed_value         (seed_value),
		.range_low          (range_low),
		.range_high         (range_high),
		.res_valid          (res_valid),
		.res_stall          (res_stall),
		.value              (value),
		.range_error        (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// result side: check every transfer, stall at random outside the calm stretch
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(value, range_error);
		res_stall <= !calm && ($urandom_range(0, 99) < 8);
	end

	function automatic cmd_t mk(input logic [1:0] op, input logic [31:0] seed,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		cmd_t c;
		c.op = op;
		c.seed = seed;
		c.lo = lo;
		c.hi = hi;
		return c;
	endfunction

	function automatic logic [31:0] edgy_word();
		case ($urandom_range(0, 7))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return 32'h00000001;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		logic signed [31:0] a, b;
		int k;
		c = mk(mtlr_pkg::FUNC_RANGE, $urandom, edgy_word(), edgy_word());
		k = $urandom_range(0, 99);
		if (k < 3) begin
			c.op = FUNC_NONE;
		end else if (k < 6) begin
			c.op = mtlr_pkg::FUNC_SEED;
			c.seed = edgy_word();
		end else if (k < 50) begin
			c.op = mtlr_pkg::FUNC_RAW;
		end else if (k < 58) begin
			// empty range: force lo above hi
			a = c.lo;
			b = c.hi;
			if (a < b) begin
				c.lo = b;
				c.hi = a;
			end else if (a == b) begin
				if (a == INT_MAX)
					c.hi = a - 1;
				else
					c.lo = a + 1;
			end
		end else if (k < 80) begin
			// narrow span, kept inside the signed range
			b = $urandom_range(0, 100);
			if (c.lo > INT_MAX - b)
				c.lo = INT_MAX - b;
			c.hi = c.lo + b;
		end else if (c.hi < c.lo) begin
			a = c.lo;
			c.lo = c.hi;
			c.hi = a;
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c);
		cmd_valid <= 1'b1;
		func <= c.op;
		seed_value <= c.seed;
		range_low <= c.lo;
		range_high <= c.hi;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sb.note_cmd(c);
		if (c.op != FUNC_NONE)
			item_count++;
		if (!calm && $urandom_range(0, 99) < 8) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// hold off until every draw is back and any seed fill has finished
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_draws.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default(input logic [31:0] v);
		default_seed_we <= 1'b1;
		default_seed_wdata <= v;
		@(posedge clk);
		default_seed_we <= 1'b0;
		sb.fallback_seed = v;
	endtask

	task automatic run_segment(input bit long_run);
		int run_len;
		cmd_t c;
		if ($urandom_range(0, 99) < 80)
			send_cmd(mk(mtlr_pkg::FUNC_SEED, edgy_word(), $urandom, $urandom));
		// long runs hold back seeds so the table is used up and twisted again
		run_len = long_run ? $urandom_range(680, 760) : $urandom_range(1, 40);
		repeat (run_len) begin
			c = random_cmd();
			if (long_run && c.op == mtlr_pkg::FUNC_SEED)
				c.op = mtlr_pkg::FUNC_RAW;
			send_cmd(c);
		end
	endtask

	task automatic run_phase(input int target, input bit with_long);
		if (with_long)
			run_segment(1'b1);
		while (item_count < target)
			run_segment(1'b0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		case ($urandom_range(0, 3))
			0: ;
			1: write_default(32'h00000000);
			2: write_default(32'hffffffff);
			default: write_default($urandom);
		endcase

		// empty ranges before any seed must not seed the table
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, 32'sd10, -32'sd5));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MAX, INT_MIN));
		send_cmd(mk(mtlr_pkg::FUNC_RAW, $urandom, INT_MIN, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MIN, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, 32'sd0, 32'sd0));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MIN, INT_MIN));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MAX, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MAX - 1, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, 32'sd0, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MIN, -32'sd1));
		send_cmd(mk(FUNC_NONE, $urandom, $urandom, $urandom));
		send_cmd(mk(mtlr_pkg::FUNC_SEED, 32'h00000000, INT_MAX, INT_MIN));
		send_cmd(mk(mtlr_pkg::FUNC_RAW, 32'hffffffff, 32'sd0, 32'sd0));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, 32'sd0, -32'sd1));
		send_cmd(mk(mtlr_pkg::FUNC_SEED, 32'hffffffff, INT_MIN, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RAW, 32'h00000000, INT_MAX, INT_MIN));
		send_cmd(mk(mtlr_pkg::FUNC_RAW, $urandom, $urandom, $urandom));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, $urandom, INT_MIN, INT_MIN + 1));
		send_cmd(mk(mtlr_pkg::FUNC_SEED, RESET_SEED, $urandom, $urandom));
		send_cmd(mk(mtlr_pkg::FUNC_RAW, $urandom, INT_MIN, INT_MAX));
		send_cmd(mk(FUNC_NONE, 32'hffffffff, INT_MIN, INT_MAX));
		send_cmd(mk(mtlr_pkg::FUNC_RANGE, 32'h00000000, -32'sd1, INT_MAX));

		wait_idle();
		write_default(32'h00000000);
		run_phase(650, 1'b1);

		wait_idle();
		write_default(32'hffffffff);
		calm = 1'b1;
		run_phase(1450, 1'b1);
		calm = 1'b0;

		wait_idle();
		write_default($urandom);
		run_phase(1900, 1'b0);

		wait_idle();
		sb.check_drained();
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
